/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given
// active-low reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the project's standard clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

/* hdl/bimt_pkg.sv */
`default_nettype none

package bimt_pkg;

  // Default number of pairs held in each table.
  localparam int unsigned ENTRIES_DEF = 64;

  // Widths of the transaction fields.
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ID_W  = 32;
  localparam int unsigned ST_W  = 2;

  // The all-ones id stands for "no id" and is never looked up.
  localparam logic [ID_W-1:0] ID_NONE = '1;

  // Operation codes of a request transaction.
  typedef enum logic [OP_W-1:0] {
    OP_ADD_USER  = 3'd0,
    OP_ADD_GROUP = 3'd1,
    OP_MAP       = 3'd2,
    OP_UNMAP     = 3'd3,
    OP_CLEAR     = 3'd4
  } bimt_op_e;

  // Status codes of a response transaction.
  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } bimt_status_e;

  // Control states of the lookup engine.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } bimt_state_e;

endpackage

`default_nettype wire

/* hdl/bimt_if.sv */
`default_nettype none

// Request channel: one operation with its ids.
interface bimt_req_if;
  logic                        valid;
  logic                        ready;
  logic [bimt_pkg::OP_W-1:0]   operation;
  logic [bimt_pkg::ID_W-1:0]   host_id;
  logic [bimt_pkg::ID_W-1:0]   stored_id;
  logic [bimt_pkg::ID_W-1:0]   user_id;
  logic [bimt_pkg::ID_W-1:0]   group_id;

  modport source (output valid, operation, host_id, stored_id, user_id, group_id,
                  input ready);
  modport sink   (input valid, operation, host_id, stored_id, user_id, group_id,
                  output ready);
endinterface

// Response channel: translated ids and a status.
interface bimt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bimt_pkg::ID_W-1:0]   mapped_user;
  logic [bimt_pkg::ID_W-1:0]   mapped_group;
  logic [bimt_pkg::ST_W-1:0]   status;

  modport source (output valid, mapped_user, mapped_group, status, input ready);
  modport sink   (input valid, mapped_user, mapped_group, status, output ready);
endinterface

// Configuration write channel for the passthrough register.
interface bimt_cfg_if;
  logic valid;
  logic ready;
  logic allow_passthrough;

  modport source (output valid, allow_passthrough, input ready);
  modport sink   (input valid, allow_passthrough, output ready);
endinterface

`default_nettype wire

/* hdl/bidirectional_id_map_table_core.sv */
// Bidirectional user/group id translation table.
// Channels: req_i takes one operation per transaction (add a user pair, add
// a group pair, map host ids to stored ids, reverse map, clear); rsp_o gives
// exactly one response transaction per request; cfg_i writes the passthrough
// register and is always ready. All channels use valid/ready.
// Sequencing: add, clear and unused codes set their result on acceptance and
// then move it into the response register. A map or reverse map reads both
// tables newest entry first, one entry per cycle from each table memory in
// parallel, until every entry below the larger count has been read; it stops
// early once both ids are found. Each table memory has one read port.
// Throughput: one request at a time; the next request is accepted once the
// previous one has moved into the response register.
// Stalls: the response register holds its transaction until rsp_o.ready;
// a request may complete behind it and then waits until the register frees.
// Reset: both tables are emptied (counts to zero), passthrough is cleared and
// no response is pending. Table memories are not cleared; only entries below
// the count are ever used.
`default_nettype none

module bidirectional_id_map_table_core #(
  parameter int unsigned ENTRIES = bimt_pkg::ENTRIES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bimt_req_if.sink    req_i,
  bimt_rsp_if.source  rsp_o,
  bimt_cfg_if.sink    cfg_i
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ID_W = bimt_pkg::ID_W;
  localparam int unsigned ST_W = bimt_pkg::ST_W;

  // Table memories: each entry holds {host id, stored id}.
  logic [2*ID_W-1:0] user_mem_q  [ENTRIES];
  logic [2*ID_W-1:0] group_mem_q [ENTRIES];
  logic [2*ID_W-1:0] user_rd_q, group_rd_q;

  bimt_pkg::bimt_state_e state_q, state_d;
  logic [CntW-1:0] ucount_q, ucount_d, gcount_q, gcount_d;
  logic            allow_q;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            rd_vld_q, rd_vld_d;
  logic            unmap_q, unmap_d;
  logic [ID_W-1:0] ukey_q, ukey_d, gkey_q, gkey_d;
  logic            ufound_q, ufound_d, gfound_q, gfound_d;
  logic [ID_W-1:0] uval_q, uval_d, gval_q, gval_d;
  logic [ID_W-1:0] res_user_q, res_user_d, res_group_q, res_group_d;
  logic [ST_W-1:0] res_st_q, res_st_d;
  logic            out_vld_q, out_vld_d;
  logic [ID_W-1:0] out_user_q, out_group_q;
  logic [ST_W-1:0] out_st_q;
  logic            out_load;

  logic            req_acc;
  logic            uwr_en, gwr_en, rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] scan_len;
  logic [ID_W-1:0] u_key_rd, u_val_rd, g_key_rd, g_val_rd;
  logic            any_miss;
  bimt_pkg::bimt_op_e op;

  assign req_i.ready = (state_q == bimt_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign op          = bimt_pkg::bimt_op_e'(req_i.operation);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.mapped_user  = out_user_q;
  assign rsp_o.mapped_group = out_group_q;
  assign rsp_o.status       = out_st_q;

  assign scan_len = (ucount_q > gcount_q) ? ucount_q : gcount_q;
  assign rd_addr  = IdxW'(ptr_q - CntW'(1));

  // The key and value halves swap for a reverse map.
  assign u_key_rd = unmap_q ? user_rd_q[ID_W-1:0]  : user_rd_q[2*ID_W-1:ID_W];
  assign u_val_rd = unmap_q ? user_rd_q[2*ID_W-1:ID_W] : user_rd_q[ID_W-1:0];
  assign g_key_rd = unmap_q ? group_rd_q[ID_W-1:0] : group_rd_q[2*ID_W-1:ID_W];
  assign g_val_rd = unmap_q ? group_rd_q[2*ID_W-1:ID_W] : group_rd_q[ID_W-1:0];
  assign any_miss = !ufound_q || !gfound_q;

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    ucount_d    = ucount_q;
    gcount_d    = gcount_q;
    ptr_d       = ptr_q;
    rd_ptr_d    = rd_ptr_q;
    rd_vld_d    = 1'b0;
    unmap_d     = unmap_q;
    ukey_d      = ukey_q;
    gkey_d      = gkey_q;
    ufound_d    = ufound_q;
    gfound_d    = gfound_q;
    uval_d      = uval_q;
    gval_d      = gval_q;
    res_user_d  = res_user_q;
    res_group_d = res_group_q;
    res_st_d    = res_st_q;
    uwr_en      = 1'b0;
    gwr_en      = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      bimt_pkg::S_IDLE: begin
        if (req_acc) begin
          res_user_d  = '0;
          res_group_d = '0;
          res_st_d    = bimt_pkg::ST_OK;
          state_d     = bimt_pkg::S_DONE;
          unique case (op) inside
            bimt_pkg::OP_ADD_USER: begin
              if (ucount_q == CntW'(ENTRIES)) begin
                res_st_d = bimt_pkg::ST_FULL;
              end else begin
                uwr_en   = 1'b1;
                ucount_d = ucount_q + CntW'(1);
              end
            end
            bimt_pkg::OP_ADD_GROUP: begin
              if (gcount_q == CntW'(ENTRIES)) begin
                res_st_d = bimt_pkg::ST_FULL;
              end else begin
                gwr_en   = 1'b1;
                gcount_d = gcount_q + CntW'(1);
              end
            end
            bimt_pkg::OP_MAP, bimt_pkg::OP_UNMAP: begin
              unmap_d  = (op == bimt_pkg::OP_UNMAP);
              ukey_d   = req_i.user_id;
              gkey_d   = req_i.group_id;
              uval_d   = req_i.user_id;
              gval_d   = req_i.group_id;
              ufound_d = (req_i.user_id == bimt_pkg::ID_NONE);
              gfound_d = (req_i.group_id == bimt_pkg::ID_NONE);
              ptr_d    = scan_len;
              state_d  = bimt_pkg::S_SCAN;
            end
            bimt_pkg::OP_CLEAR: begin
              ucount_d = '0;
              gcount_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      bimt_pkg::S_SCAN: begin
        // Compare the entries read in the previous cycle.
        if (rd_vld_q) begin
          if (!ufound_q && (rd_ptr_q <= ucount_q) && (u_key_rd == ukey_q)) begin
            ufound_d = 1'b1;
            uval_d   = u_val_rd;
          end
          if (!gfound_q && (rd_ptr_q <= gcount_q) && (g_key_rd == gkey_q)) begin
            gfound_d = 1'b1;
            gval_d   = g_val_rd;
          end
        end
        if ((ufound_q && gfound_q) || (ptr_q == '0 && !rd_vld_q)) begin
          // Lookup finished: either both ids resolved or every entry seen.
          res_user_d  = uval_q;
          res_group_d = gval_q;
          res_st_d    = (any_miss && !allow_q) ? bimt_pkg::ST_MISS : bimt_pkg::ST_OK;
          state_d     = bimt_pkg::S_DONE;
        end else if (ptr_q != '0) begin
          // Read the next older entry of both tables.
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_ptr_d = ptr_q;
          ptr_d    = ptr_q - CntW'(1);
        end
      end

      bimt_pkg::S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = bimt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bimt_pkg::S_IDLE;
      end
    endcase
  end

  // The response register frees on a taken transaction and fills on a load.
  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bimt_pkg::S_IDLE;
      ucount_q  <= '0;
      gcount_q  <= '0;
      allow_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ucount_q  <= ucount_d;
      gcount_q  <= gcount_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        allow_q <= cfg_i.allow_passthrough;
      end
    end
  end

  // Lookup and result payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    rd_ptr_q    <= rd_ptr_d;
    unmap_q     <= unmap_d;
    ukey_q      <= ukey_d;
    gkey_q      <= gkey_d;
    ufound_q    <= ufound_d;
    gfound_q    <= gfound_d;
    uval_q      <= uval_d;
    gval_q      <= gval_d;
    res_user_q  <= res_user_d;
    res_group_q <= res_group_d;
    res_st_q    <= res_st_d;
    if (out_load) begin
      out_user_q  <= res_user_q;
      out_group_q <= res_group_q;
      out_st_q    <= res_st_q;
    end
  end

  // User table memory: appended at the count, read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (uwr_en) begin
      user_mem_q[IdxW'(ucount_q)] <= {req_i.host_id, req_i.stored_id};
    end
    if (rd_en) begin
      user_rd_q <= user_mem_q[rd_addr];
    end
  end

  // Group table memory, organised the same way.
  always_ff @(posedge clk_i) begin
    if (gwr_en) begin
      group_mem_q[IdxW'(gcount_q)] <= {req_i.host_id, req_i.stored_id};
    end
    if (rd_en) begin
      group_rd_q <= group_mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bimt_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module bimt_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_valid_i,
  input wire logic                      req_ready_i,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic [bimt_pkg::ID_W-1:0] rsp_user_i,
  input wire logic [bimt_pkg::ID_W-1:0] rsp_group_i,
  input wire logic [bimt_pkg::ST_W-1:0] rsp_status_i
);

  // A stalled response keeps its transaction unchanged.
  `ASSERT_STD(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_user_i) && $stable(rsp_group_i) && $stable(rsp_status_i), "response changed while stalled")

  // One request at a time: after an accepted request the block is busy.
  `ASSERT_STD(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "request accepted while busy")

  // A full table only arises from an add, whose ids are zero.
  `ASSERT_STD(a_full_zero_ids, rsp_valid_i && rsp_status_i == bimt_pkg::ST_FULL |-> rsp_user_i == '0 && rsp_group_i == '0, "full status with non-zero ids")

  // Only defined status codes are ever reported.
  `ASSERT_STD(a_status_code, rsp_valid_i |-> rsp_status_i == bimt_pkg::ST_OK || rsp_status_i == bimt_pkg::ST_MISS || rsp_status_i == bimt_pkg::ST_FULL, "undefined status code")

endmodule

bind bidirectional_id_map_table_core bimt_checker u_bimt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_user_i   (rsp_o.mapped_user),
  .rsp_group_i  (rsp_o.mapped_group),
  .rsp_status_i (rsp_o.status)
);

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bimt_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int unsigned USR_TBL     = 0;
  localparam int unsigned GRP_TBL     = 1;
  localparam int unsigned IDLE_PCT    = 23;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = ENTRIES + 16;
  localparam logic [OP_W-1:0] OP_UNUSED_MIN = OP_W'(OP_CLEAR + 1);
  localparam logic [OP_W-1:0] OP_UNUSED_MAX = '1;

  typedef logic [ID_W-1:0] id_t;

  typedef struct packed {
    id_t          mapped_user;
    id_t          mapped_group;
    bimt_status_e status;
  } id_rsp_t;

  logic clk_i;
  logic rst_ni;

  bimt_req_if req_if ();
  bimt_rsp_if rsp_if ();
  bimt_cfg_if cfg_if ();

  bidirectional_id_map_table_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of both translation tables and the passthrough register.
  id_t         host_tbl   [2][ENTRIES];
  id_t         stored_tbl [2][ENTRIES];
  int unsigned pair_cnt   [2];
  bit          passthrough_en;

  // Responses still owed by the block, oldest first.
  id_rsp_t     pending_rsps[$];
  int unsigned fail_cnt;
  int unsigned quiet_cycles;
  bit          steady;

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Translates one id through one table, newest pair first.
  function automatic id_t translate_id(input int unsigned tbl, input bit reverse,
                                       input id_t id, inout bit miss);
    id_t key;
    id_t res;
    bit  found;
    found = (id == ID_NONE);
    res   = id;
    for (int i = int'(pair_cnt[tbl]) - 1; i >= 0 && !found; i--) begin
      key = reverse ? stored_tbl[tbl][i] : host_tbl[tbl][i];
      if (key == id) begin
        res   = reverse ? host_tbl[tbl][i] : stored_tbl[tbl][i];
        found = 1'b1;
      end
    end
    if (!found) begin
      miss = 1'b1;
    end
    return res;
  endfunction

  // Applies one accepted request to the shadow tables and gives its response.
  function automatic id_rsp_t apply_request(input logic [OP_W-1:0] op, input id_t hid,
                                            input id_t sid, input id_t uid, input id_t gid);
    id_rsp_t     rsp;
    int unsigned tbl;
    bit          miss;
    rsp  = '0;
    rsp.status = ST_OK;
    miss = 1'b0;
    case (op)
      OP_ADD_USER, OP_ADD_GROUP: begin
        tbl = (op == OP_ADD_USER) ? USR_TBL : GRP_TBL;
        if (pair_cnt[tbl] >= ENTRIES) begin
          rsp.status = ST_FULL;
        end else begin
          host_tbl[tbl][pair_cnt[tbl]]   = hid;
          stored_tbl[tbl][pair_cnt[tbl]] = sid;
          pair_cnt[tbl]++;
        end
      end
      OP_MAP, OP_UNMAP: begin
        rsp.mapped_user  = translate_id(USR_TBL, op == OP_UNMAP, uid, miss);
        rsp.mapped_group = translate_id(GRP_TBL, op == OP_UNMAP, gid, miss);
        if (miss && !passthrough_en) begin
          rsp.status = ST_MISS;
        end
      end
      OP_CLEAR: begin
        pair_cnt[USR_TBL] = 0;
        pair_cnt[GRP_TBL] = 0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Random id, biased towards a small pool so that duplicates and hits occur.
  function automatic id_t pick_id();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      return id_t'($urandom_range(15));
    end else if (roll < 55) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return {1'b1, {(ID_W-1){1'b0}}};
        2:       return {1'b0, {(ID_W-1){1'b1}}};
        default: return ID_NONE - 1;
      endcase
    end else if (roll < 58) begin
      return ID_NONE;
    end
    return id_t'($urandom);
  endfunction

  // Id to look up: mostly a key that is present, sometimes the none id.
  function automatic id_t pick_lookup(input int unsigned tbl, input bit reverse);
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return ID_NONE;
    end
    if (roll < 70 && pair_cnt[tbl] > 0) begin
      idx = $urandom_range(pair_cnt[tbl] - 1);
      return reverse ? stored_tbl[tbl][idx] : host_tbl[tbl][idx];
    end
    return pick_id();
  endfunction

  // Sends one request transaction, with random idle cycles ahead of it.
  // Entered and left at a falling edge; valid stays high on return.
  task automatic send_request(input logic [OP_W-1:0] op, input id_t hid, input id_t sid,
                              input id_t uid, input id_t gid);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.host_id   <= hid;
    req_if.stored_id <= sid;
    req_if.user_id   <= uid;
    req_if.group_id  <= gid;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsps.push_back(apply_request(op, hid, sid, uid, gid));
    @(negedge clk_i);
  endtask

  // Add of a random pair to the table that op names; other fields are noise.
  task automatic send_random_add(input logic [OP_W-1:0] op);
    send_request(op, pick_id(), pick_id(), id_t'($urandom), id_t'($urandom));
  endtask

  // Map or reverse map of ids chosen to hit most of the time.
  task automatic send_random_lookup(input logic [OP_W-1:0] op);
    send_request(op, id_t'($urandom), id_t'($urandom),
                 pick_lookup(USR_TBL, op == OP_UNMAP), pick_lookup(GRP_TBL, op == OP_UNMAP));
  endtask

  // Waits at falling edges until every owed response has arrived.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_rsps.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Writes the passthrough register once the block is idle.
  task automatic write_passthrough(input bit value);
    wait_drained();
    cfg_if.valid             <= 1'b1;
    cfg_if.allow_passthrough <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    passthrough_en = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Hand-picked transactions: none ids, misses, duplicates, extremes and
  // unused operation codes.
  task automatic test_directed_cases();
    send_request(OP_CLEAR, ID_NONE, ID_NONE, ID_NONE, ID_NONE);
    send_request(OP_MAP, '0, '0, ID_NONE, ID_NONE);
    send_request(OP_MAP, '0, '0, '0, '0);
    send_request(OP_UNMAP, '0, '0, ID_NONE, '0);
    send_request(OP_ADD_USER, '0, ID_NONE, '0, '0);
    send_request(OP_ADD_USER, ID_NONE, '0, '0, '0);
    send_request(OP_ADD_USER, 32'd5, 32'd100, '0, '0);
    send_request(OP_ADD_USER, 32'd5, 32'd200, '0, '0);
    send_request(OP_ADD_GROUP, 32'd7, 32'd300, '0, '0);
    send_request(OP_ADD_GROUP, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_request(OP_MAP, '0, '0, 32'd5, 32'd7);
    send_request(OP_MAP, '0, '0, '0, 32'h8000_0000);
    send_request(OP_UNMAP, '0, '0, 32'd200, 32'd300);
    send_request(OP_UNMAP, '0, '0, 32'd100, 32'h7fff_ffff);
    send_request(OP_UNMAP, '0, '0, '0, ID_NONE);
    send_request(OP_MAP, '0, '0, 32'd5, 32'd8);
    send_request(OP_UNUSED_MIN, ID_NONE, ID_NONE, ID_NONE, ID_NONE);
    send_request(OP_W'(OP_UNUSED_MIN + 1), ID_NONE, ID_NONE, 32'd5, 32'd7);
    send_request(OP_UNUSED_MAX, 32'd9, 32'd9, 32'd5, 32'd7);
    send_request(OP_MAP, '0, '0, ID_NONE, 32'd7);
    send_request(OP_CLEAR, '0, '0, '0, '0);
    send_request(OP_MAP, '0, '0, 32'd5, 32'd7);
    send_request(OP_ADD_GROUP, 32'd1, 32'd2, '0, '0);
    send_request(OP_UNMAP, '0, '0, ID_NONE - 1, 32'd2);
  endtask

  // Fills both tables past capacity with no idling on either side, looking
  // up along the way, then checks that a clear makes room again.
  task automatic test_table_capacity();
    steady = 1'b1;
    send_request(OP_CLEAR, id_t'($urandom), id_t'($urandom), '0, '0);
    for (int i = 0; i < int'(ENTRIES) + 3; i++) begin
      send_random_add(OP_ADD_USER);
      send_random_add(OP_ADD_GROUP);
      if (i % 8 == 7) begin
        send_random_lookup((i % 16 == 7) ? OP_MAP : OP_UNMAP);
      end
    end
    repeat (20) begin
      send_random_lookup($urandom_range(1) ? OP_MAP : OP_UNMAP);
    end
    send_request(OP_CLEAR, '0, '0, '0, '0);
    send_random_add(OP_ADD_USER);
    send_random_add(OP_ADD_GROUP);
    send_random_lookup(OP_MAP);
    send_random_lookup(OP_UNMAP);
    steady = 1'b0;
  endtask

  // Mixed random traffic; a low clear rate lets the tables fill up.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned clear_pct);
    int unsigned roll;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < clear_pct) begin
        send_request(OP_CLEAR, id_t'($urandom), id_t'($urandom),
                     id_t'($urandom), id_t'($urandom));
      end else if (roll < clear_pct + 2) begin
        send_request(OP_W'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN)), id_t'($urandom),
                     id_t'($urandom), id_t'($urandom), id_t'($urandom));
      end else if (roll < 42) begin
        send_random_add($urandom_range(1) ? OP_ADD_USER : OP_ADD_GROUP);
      end else if (roll < 71) begin
        send_random_lookup(OP_MAP);
      end else begin
        send_random_lookup(OP_UNMAP);
      end
    end
  endtask

  // Response side stalls at random, except during the steady stretch.
  always @(negedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Cycles with no transaction on any channel, for the watchdog.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Compares one response field and reports a mismatch.
  function automatic void check_field(input string field, input id_t want, input id_t got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endfunction

  // Response checker: each accepted transaction against the oldest owed one.
  always @(posedge clk_i) begin
    id_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsps.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected response, expected none actual %h %h %h", $time,
                 rsp_if.mapped_user, rsp_if.mapped_group, rsp_if.status);
      end else begin
        want = pending_rsps.pop_front();
        check_field("mapped_user", want.mapped_user, rsp_if.mapped_user);
        check_field("mapped_group", want.mapped_group, rsp_if.mapped_group);
        check_field("status", id_t'(want.status), id_t'(rsp_if.status));
      end
    end
  end

  // Watchdog: ends the run if the channels fall silent for too long.
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
    end
    $display("tb: failure");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni                   = 1'b0;
    steady                   = 1'b0;
    passthrough_en           = 1'b0;
    pair_cnt[USR_TBL]        = 0;
    pair_cnt[GRP_TBL]        = 0;
    req_if.valid             = 1'b0;
    req_if.operation         = OP_CLEAR;
    req_if.host_id           = '0;
    req_if.stored_id         = '0;
    req_if.user_id           = '0;
    req_if.group_id          = '0;
    cfg_if.valid             = 1'b0;
    cfg_if.allow_passthrough = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_passthrough(1'b0);
    test_directed_cases();
    write_passthrough(1'b1);
    test_random_traffic(350, 3);
    write_passthrough(1'b0);
    test_table_capacity();
    test_random_traffic(400, 2);
    write_passthrough(1'b1);
    test_random_traffic(350, 1);
    write_passthrough(1'b0);
    test_random_traffic(250, 0);

    // Let everything owed arrive, then allow for any late response.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* bidirectional_id_map_table_core.f */
+incdir+hdl
hdl/bimt_pkg.sv
hdl/bimt_if.sv
hdl/bidirectional_id_map_table_core.sv
hdl/bimt_checker.sv
test/tb_top.sv
